@@ hw/rtl/apm_pkg.sv @@
// Shared types, constants and command codes for the audio peak and RMS meter.
`default_nettype none
package apm_pkg;

  localparam int unsigned SampleW  = 24;
  localparam int unsigned LevelW   = 23;
  localparam int unsigned SquareW  = 2 * SampleW;
  localparam int unsigned SumW     = 59;
  localparam int unsigned CountW   = 13;
  localparam int unsigned CoefW    = 16;
  localparam int unsigned RmsW     = LevelW + CoefW;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned TimeAvgW = TimeW + CoefW;
  localparam int unsigned EmaW     = TimeAvgW;
  localparam int unsigned ProdW    = EmaW + CoefW;
  localparam int unsigned SqrtW    = SumW + 1;
  localparam int unsigned DivSteps  = SumW;
  localparam int unsigned SqrtSteps = SqrtW / 2;
  localparam int unsigned StepCntW  = 6;

  localparam logic [CountW-1:0]  MaxBlock   = CountW'(4096);
  localparam logic [SampleW-1:0] ClipLevel  = SampleW'(8380220);
  localparam logic [LevelW-1:0]  LevelMax   = {LevelW{1'b1}};
  localparam logic [CoefW-1:0]   TimeWeight = CoefW'(3277);
  localparam logic [CoefW-1:0]   DecayReset = CoefW'(62259);
  localparam logic [CoefW-1:0]   AlphaReset = CoefW'(2124);

  typedef enum logic [0:0] {
    REG_PEAK_DECAY = 1'b0,
    REG_RMS_ALPHA  = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic                      req_type;
    logic signed [SampleW-1:0] in_sample;
    logic signed [SampleW-1:0] out_sample;
    logic                      last_frame;
    logic [TimeW-1:0]          elapsed_ns;
  } in_word_t;

  typedef struct packed {
    logic [LevelW-1:0] in_peak_level;
    logic [LevelW-1:0] out_peak_level;
    logic [LevelW-1:0] in_rms_level;
    logic [LevelW-1:0] out_rms_level;
    logic [TimeW-1:0]  clip_total;
    logic [TimeW-1:0]  block_total;
    logic [TimeW-1:0]  time_last_ns;
    logic [TimeW-1:0]  time_avg_ns;
    logic [TimeW-1:0]  time_max_ns;
  } out_word_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_CAPTURE,
    OP_SQUARE,
    OP_CLEAR,
    OP_ACCUM,
    OP_DIV_LOAD,
    OP_DIV_STEP,
    OP_SQRT_LOAD,
    OP_SQRT_STEP,
    OP_EMA_DIFF,
    OP_EMA_MUL,
    OP_EMA_ADD,
    OP_PEAK_MUL,
    OP_FINISH
  } op_e;

  typedef enum logic [1:0] {
    SEL_IN,
    SEL_OUT,
    SEL_TIME
  } sel_e;

  typedef struct packed {
    op_e  op;
    sel_e sel;
  } cmd_t;

  typedef struct packed {
    logic req_clear;
    logic last;
    logic out_stall;
  } status_t;

endpackage
`default_nettype wire

@@ hw/rtl/apm_ctrl.sv @@
// Sequencer for the meter: steps the datapath through each word and the end-of-block work.
`default_nettype none
module apm_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire apm_pkg::status_t status_i,
  output apm_pkg::cmd_t        cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_ACCUM,
    S_DIV_LOAD,
    S_DIV,
    S_SQRT_LOAD,
    S_SQRT,
    S_EMA_DIFF,
    S_EMA_MUL,
    S_EMA_ADD,
    S_PEAK,
    S_FINISH
  } state_e;

  state_e                         state_q;
  apm_pkg::sel_e                  sel_q;
  logic [apm_pkg::StepCntW-1:0]   cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      sel_q   <= apm_pkg::SEL_IN;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) state_q <= S_DECODE;
        end
        S_DECODE: begin
          state_q <= status_i.req_clear ? S_IDLE : S_ACCUM;
        end
        S_ACCUM: begin
          sel_q   <= apm_pkg::SEL_IN;
          state_q <= status_i.last ? S_DIV_LOAD : S_IDLE;
        end
        S_DIV_LOAD: begin
          cnt_q   <= '0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == apm_pkg::StepCntW'(apm_pkg::DivSteps - 1)) state_q <= S_SQRT_LOAD;
        end
        S_SQRT_LOAD: begin
          cnt_q   <= '0;
          state_q <= S_SQRT;
        end
        S_SQRT: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == apm_pkg::StepCntW'(apm_pkg::SqrtSteps - 1)) state_q <= S_EMA_DIFF;
        end
        S_EMA_DIFF: state_q <= S_EMA_MUL;
        S_EMA_MUL:  state_q <= S_EMA_ADD;
        S_EMA_ADD: begin
          case (sel_q)
            apm_pkg::SEL_IN: begin
              sel_q   <= apm_pkg::SEL_OUT;
              state_q <= S_DIV_LOAD;
            end
            apm_pkg::SEL_OUT: begin
              sel_q   <= apm_pkg::SEL_TIME;
              state_q <= S_EMA_DIFF;
            end
            default: state_q <= S_PEAK;
          endcase
        end
        S_PEAK: state_q <= S_FINISH;
        S_FINISH: begin
          if (!status_i.out_stall) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd_o.sel = sel_q;
    case (state_q)
      S_IDLE:      cmd_o.op = in_valid_i ? apm_pkg::OP_CAPTURE : apm_pkg::OP_NOP;
      S_DECODE:    cmd_o.op = status_i.req_clear ? apm_pkg::OP_CLEAR : apm_pkg::OP_SQUARE;
      S_ACCUM:     cmd_o.op = apm_pkg::OP_ACCUM;
      S_DIV_LOAD:  cmd_o.op = apm_pkg::OP_DIV_LOAD;
      S_DIV:       cmd_o.op = apm_pkg::OP_DIV_STEP;
      S_SQRT_LOAD: cmd_o.op = apm_pkg::OP_SQRT_LOAD;
      S_SQRT:      cmd_o.op = apm_pkg::OP_SQRT_STEP;
      S_EMA_DIFF:  cmd_o.op = apm_pkg::OP_EMA_DIFF;
      S_EMA_MUL:   cmd_o.op = apm_pkg::OP_EMA_MUL;
      S_EMA_ADD:   cmd_o.op = apm_pkg::OP_EMA_ADD;
      S_PEAK:      cmd_o.op = apm_pkg::OP_PEAK_MUL;
      S_FINISH:    cmd_o.op = status_i.out_stall ? apm_pkg::OP_NOP : apm_pkg::OP_FINISH;
      default:     cmd_o.op = apm_pkg::OP_NOP;
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule
`default_nettype wire

@@ hw/rtl/apm_dp.sv @@
// Datapath of the meter: accumulators, serial divider, serial square root, averaging unit.
`default_nettype none
module apm_dp (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire apm_pkg::cmd_t                 cmd_i,
  output apm_pkg::status_t                   status_o,
  input  wire apm_pkg::in_word_t             in_word_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [0:0]                    cfg_idx_i,
  input  wire logic [apm_pkg::CoefW-1:0]     cfg_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output apm_pkg::out_word_t                 out_word_o
);

  localparam int unsigned SW = apm_pkg::SampleW;
  localparam int unsigned LW = apm_pkg::LevelW;
  localparam int unsigned CW = apm_pkg::CoefW;
  localparam int unsigned TW = apm_pkg::TimeW;
  localparam int unsigned DW = LW + CW;

  // Configuration and accumulated state.
  logic [CW-1:0]                  peak_decay_q, rms_alpha_q;
  logic [LW-1:0]                  in_peak_acc_q, out_peak_acc_q;
  logic [apm_pkg::SumW-1:0]       in_sum_q, out_sum_q;
  logic [apm_pkg::CountW-1:0]     frame_cnt_q, blk_clip_q;
  logic [LW-1:0]                  in_hold_q, out_hold_q;
  logic [apm_pkg::RmsW-1:0]       in_rms_q, out_rms_q;
  logic [TW-1:0]                  clip_cnt_q, block_cnt_q, time_last_q, time_max_q;
  logic [apm_pkg::TimeAvgW-1:0]   time_avg_q;
  logic                           out_valid_q;

  // Working registers.
  apm_pkg::in_word_t              word_q;
  logic [SW-1:0]                  in_mag_q, out_mag_q;
  logic [apm_pkg::SquareW-1:0]    in_sq_q, out_sq_q;
  logic                           clip_hit_q, take_q;
  logic [apm_pkg::SumW-1:0]       quo_q;
  logic [apm_pkg::CountW-1:0]     rem_q;
  logic [apm_pkg::SqrtW-1:0]      sq_x_q, sq_res_q, sq_bit_q;
  logic [apm_pkg::EmaW-1:0]       diff_q;
  logic                           up_q;
  logic [apm_pkg::ProdW-1:0]      prod_q;
  logic [LW-1:0]                  in_dec_q, out_dec_q;
  apm_pkg::out_word_t             out_q;

  // Sample magnitudes; full scale negative gives 2^23.
  logic [SW-1:0] in_mag, out_mag;
  assign in_mag  = word_q.in_sample[SW-1]  ? SW'(-$unsigned(word_q.in_sample))
                                           : $unsigned(word_q.in_sample);
  assign out_mag = word_q.out_sample[SW-1] ? SW'(-$unsigned(word_q.out_sample))
                                           : $unsigned(word_q.out_sample);

  logic [LW-1:0] in_pk, out_pk;
  assign in_pk  = in_mag_q[SW-1]  ? apm_pkg::LevelMax : in_mag_q[LW-1:0];
  assign out_pk = out_mag_q[SW-1] ? apm_pkg::LevelMax : out_mag_q[LW-1:0];

  // Restoring divider step.
  logic [apm_pkg::CountW:0]   trial;
  logic                       div_ge;
  logic [apm_pkg::CountW-1:0] rem_d;
  assign trial  = {rem_q, quo_q[apm_pkg::SumW-1]};
  assign div_ge = trial >= {1'b0, frame_cnt_q};
  assign rem_d  = div_ge ? apm_pkg::CountW'(trial - {1'b0, frame_cnt_q})
                         : trial[apm_pkg::CountW-1:0];

  // Square root step.
  logic [apm_pkg::SqrtW-1:0] sq_t;
  logic                      sq_ge;
  assign sq_t  = sq_res_q + sq_bit_q;
  assign sq_ge = sq_x_q >= sq_t;

  logic [LW-1:0] rms_tgt;
  assign rms_tgt = (|sq_res_q[apm_pkg::SqrtW-1:LW]) ? apm_pkg::LevelMax : sq_res_q[LW-1:0];

  // Peak release products at full width.
  logic [DW-1:0] in_dec_prod, out_dec_prod;
  assign in_dec_prod  = DW'(in_hold_q) * DW'(peak_decay_q);
  assign out_dec_prod = DW'(out_hold_q) * DW'(peak_decay_q);

  // Averaging unit operands.
  logic [apm_pkg::EmaW-1:0] ema_avg, ema_tgt, ema_step, ema_new;
  logic [CW-1:0]            ema_w;
  always_comb begin
    case (cmd_i.sel)
      apm_pkg::SEL_IN: begin
        ema_avg = apm_pkg::EmaW'(in_rms_q);
        ema_tgt = apm_pkg::EmaW'({rms_tgt, {CW{1'b0}}});
        ema_w   = rms_alpha_q;
      end
      apm_pkg::SEL_OUT: begin
        ema_avg = apm_pkg::EmaW'(out_rms_q);
        ema_tgt = apm_pkg::EmaW'({rms_tgt, {CW{1'b0}}});
        ema_w   = rms_alpha_q;
      end
      default: begin
        ema_avg = time_avg_q;
        ema_tgt = {word_q.elapsed_ns, {CW{1'b0}}};
        ema_w   = apm_pkg::TimeWeight;
      end
    endcase
  end
  assign ema_step = prod_q[apm_pkg::ProdW-1:CW];
  assign ema_new  = up_q ? ema_avg + ema_step : ema_avg - ema_step;

  // End-of-block results.
  logic [LW-1:0] in_hold_d, out_hold_d;
  logic [TW-1:0] clip_cnt_d, block_cnt_d, time_max_d;
  assign in_hold_d   = (in_peak_acc_q > in_dec_q) ? in_peak_acc_q : in_dec_q;
  assign out_hold_d  = (out_peak_acc_q > out_dec_q) ? out_peak_acc_q : out_dec_q;
  assign clip_cnt_d  = clip_cnt_q + TW'(blk_clip_q);
  assign block_cnt_d = block_cnt_q + 1'b1;
  assign time_max_d  = (word_q.elapsed_ns > time_max_q) ? word_q.elapsed_ns : time_max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_decay_q   <= apm_pkg::DecayReset;
      rms_alpha_q    <= apm_pkg::AlphaReset;
      in_peak_acc_q  <= '0;
      out_peak_acc_q <= '0;
      in_sum_q       <= '0;
      out_sum_q      <= '0;
      frame_cnt_q    <= '0;
      blk_clip_q     <= '0;
      in_hold_q      <= '0;
      out_hold_q     <= '0;
      in_rms_q       <= '0;
      out_rms_q      <= '0;
      clip_cnt_q     <= '0;
      block_cnt_q    <= '0;
      time_last_q    <= '0;
      time_avg_q     <= '0;
      time_max_q     <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          apm_pkg::REG_PEAK_DECAY: peak_decay_q <= cfg_data_i;
          apm_pkg::REG_RMS_ALPHA:  rms_alpha_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      case (cmd_i.op)
        apm_pkg::OP_CLEAR: begin
          time_max_q <= '0;
          clip_cnt_q <= '0;
        end
        apm_pkg::OP_ACCUM: begin
          if (take_q) begin
            if (in_pk > in_peak_acc_q)   in_peak_acc_q  <= in_pk;
            if (out_pk > out_peak_acc_q) out_peak_acc_q <= out_pk;
            in_sum_q    <= in_sum_q + apm_pkg::SumW'(in_sq_q);
            out_sum_q   <= out_sum_q + apm_pkg::SumW'(out_sq_q);
            blk_clip_q  <= blk_clip_q + apm_pkg::CountW'(clip_hit_q);
            frame_cnt_q <= frame_cnt_q + 1'b1;
          end
        end
        apm_pkg::OP_EMA_ADD: begin
          case (cmd_i.sel)
            apm_pkg::SEL_IN:  in_rms_q   <= ema_new[apm_pkg::RmsW-1:0];
            apm_pkg::SEL_OUT: out_rms_q  <= ema_new[apm_pkg::RmsW-1:0];
            default:          time_avg_q <= ema_new;
          endcase
        end
        apm_pkg::OP_FINISH: begin
          in_hold_q      <= in_hold_d;
          out_hold_q     <= out_hold_d;
          clip_cnt_q     <= clip_cnt_d;
          block_cnt_q    <= block_cnt_d;
          time_last_q    <= word_q.elapsed_ns;
          time_max_q     <= time_max_d;
          in_peak_acc_q  <= '0;
          out_peak_acc_q <= '0;
          in_sum_q       <= '0;
          out_sum_q      <= '0;
          frame_cnt_q    <= '0;
          blk_clip_q     <= '0;
          out_valid_q    <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      apm_pkg::OP_CAPTURE: word_q <= in_word_i;
      apm_pkg::OP_SQUARE: begin
        in_mag_q   <= in_mag;
        out_mag_q  <= out_mag;
        in_sq_q    <= in_mag * in_mag;
        out_sq_q   <= out_mag * out_mag;
        clip_hit_q <= out_mag >= apm_pkg::ClipLevel;
        take_q     <= frame_cnt_q < apm_pkg::MaxBlock;
      end
      apm_pkg::OP_DIV_LOAD: begin
        quo_q <= (cmd_i.sel == apm_pkg::SEL_IN) ? in_sum_q : out_sum_q;
        rem_q <= '0;
      end
      apm_pkg::OP_DIV_STEP: begin
        quo_q <= {quo_q[apm_pkg::SumW-2:0], div_ge};
        rem_q <= rem_d;
      end
      apm_pkg::OP_SQRT_LOAD: begin
        sq_x_q   <= apm_pkg::SqrtW'(quo_q);
        sq_res_q <= '0;
        sq_bit_q <= apm_pkg::SqrtW'(1) << (apm_pkg::SqrtW - 2);
      end
      apm_pkg::OP_SQRT_STEP: begin
        if (sq_ge) begin
          sq_x_q   <= sq_x_q - sq_t;
          sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
        end else begin
          sq_res_q <= sq_res_q >> 1;
        end
        sq_bit_q <= sq_bit_q >> 2;
      end
      apm_pkg::OP_EMA_DIFF: begin
        up_q   <= ema_tgt >= ema_avg;
        diff_q <= (ema_tgt >= ema_avg) ? ema_tgt - ema_avg : ema_avg - ema_tgt;
      end
      apm_pkg::OP_EMA_MUL: prod_q <= diff_q * ema_w;
      apm_pkg::OP_PEAK_MUL: begin
        in_dec_q  <= in_dec_prod[DW-1:CW];
        out_dec_q <= out_dec_prod[DW-1:CW];
      end
      apm_pkg::OP_FINISH: begin
        out_q.in_peak_level  <= in_hold_d;
        out_q.out_peak_level <= out_hold_d;
        out_q.in_rms_level   <= in_rms_q[apm_pkg::RmsW-1:CW];
        out_q.out_rms_level  <= out_rms_q[apm_pkg::RmsW-1:CW];
        out_q.clip_total     <= clip_cnt_d;
        out_q.block_total    <= block_cnt_d;
        out_q.time_last_ns   <= word_q.elapsed_ns;
        out_q.time_avg_ns    <= time_avg_q[apm_pkg::TimeAvgW-1:CW];
        out_q.time_max_ns    <= time_max_d;
      end
      default: ;
    endcase
  end

  assign status_o.req_clear = word_q.req_type;
  assign status_o.last      = word_q.last_frame;
  assign status_o.out_stall = out_valid_q && !out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule
`default_nettype wire

@@ hw/rtl/audio_peak_rms_meter_top.sv @@
// Top level of the audio peak and RMS level meter.
//
// Input words arrive on a valid/ready channel, one audio frame (one input and one
// output sample) or one clear request per word. Results leave on a second
// valid/ready channel, one word per audio block, issued for the frame marked last.
// The block works on one word at a time; in_ready_o is high only while it is idle.
// A clear request passes through the decode state only; an ordinary frame also accumulates.
// A last frame runs the end-of-block sequence: a bit-serial divider and a bit-serial
// square root for each channel, shared by both, plus the averaging multiplier and
// the peak release step. The finishing step waits while the output is stalled;
// once it has written the result word, the next word can be taken.
// The result sits in an output register; if the receiver stalls, a finished word
// waits there, and the next block result holds until it has been taken.
// Configuration writes (peak_decay at index 0, rms_alpha at index 1) take effect
// at once and are meant for idle periods. Reset is asynchronous, active low; it
// clears all meters and counters and loads the default coefficients. No clearing
// pass is needed after reset.
`default_nettype none
module audio_peak_rms_meter_top (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire apm_pkg::in_word_t         in_word_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output apm_pkg::out_word_t             out_word_o,
  input  wire logic                      cfg_we_i,
  input  wire logic [0:0]                cfg_idx_i,
  input  wire logic [apm_pkg::CoefW-1:0] cfg_data_i
);

  apm_pkg::cmd_t    cmd;
  apm_pkg::status_t status;

  // The sequencer decides what the datapath does in each cycle.
  apm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // The datapath holds every meter, the shared arithmetic units and the result.
  apm_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_word_i   (in_word_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

`ifndef SYNTHESIS
  // A result word only appears after the finishing step.
  a_result_from_finish : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(cmd.op == apm_pkg::OP_FINISH))
    else $error("result word appeared without a finishing step");

  // Once a word is taken the block is busy in the next cycle.
  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input taken while still busy");

  // A clear request returns to idle after its decode step, without accumulating.
  a_clear_is_short : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_word_i.req_type) |=> ##1 in_ready_o)
    else $error("clear request did not return to idle");
`endif

endmodule
`default_nettype wire
